>>> hw/rtl/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

    localparam int BlockBytes = 64;
    localparam int Rounds     = 64;
    localparam int DigestWords = 8;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Control from the sequencer to the round datapath
    typedef struct packed {
        logic       init;    // load working vars from chain words
        logic       step;    // run one round
        logic [5:0] round;
        logic       fold;    // add working vars into chain words
    } core_ctl_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

>>> hw/rtl/sha256_core.sv
// Round datapath: 16-word message schedule window, working variables, chain words.
module sha256_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha256_pkg::core_ctl_t ctl,
    input  logic                  restart,      // reload initial hash values
    input  logic                  w_load,       // shift a buffer word into the window
    input  logic [31:0]           w_in,
    input  logic [2:0]            h_sel,
    output logic [31:0]           h_word
);

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [31:0] w_new, t1, t2, ch, maj;

    // next schedule word, from the window of the last sixteen
    assign w_new = sha256_pkg::ssig1(w_reg[14]) + w_reg[9]
                 + sha256_pkg::ssig0(w_reg[1]) + w_reg[0];
    assign ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1    = v_reg[7] + sha256_pkg::bsig1(v_reg[4]) + ch
                 + sha256_pkg::ROUND_K[ctl.round] + w_reg[0];
    assign t2    = sha256_pkg::bsig0(v_reg[0]) + maj;
    assign h_word = h_reg[h_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha256_pkg::INIT_H[i];
        end
        else if (restart)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha256_pkg::INIT_H[i];
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_load || ctl.step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_load ? w_in : w_new;
        end
        if (ctl.init)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (ctl.step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

>>> hw/rtl/sha256_stream_hasher_top.sv
// Top level of the streaming SHA-256 hasher: block buffer memory and sequencer.
// Usage: an absorb item is taken while in_stall is low and written into a
// 16 x 32-bit block buffer memory (one synchronous port). The 64th byte of a
// block starts a compression: the buffer words stream into the schedule
// window (one memory read per cycle), the last word lands in the window, the
// 64 rounds run and the result is folded into the chain words; input stalls
// until the block is idle again. A finish item writes the padding (up to 16
// words), one word per cycle, compresses once, or twice when 56 or more bytes
// were pending, and then offers the eight digest words H0 first, one per cycle
// when out_stall is low. The block then starts the next message.
module sha256_stream_hasher_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sha256_pkg::in_item_t   in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sha256_pkg::out_item_t  out_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [5:0]  pend_reg;       // bytes pending in the block
    logic [63:0] bits_reg;
    logic        fin_reg;        // finishing the message
    logic        extra_reg;      // a length-only block still follows
    logic [3:0]  widx_reg;       // word index for pad and load sweeps
    logic [5:0]  round_reg;
    logic [2:0]  oidx_reg;
    logic [31:0] word_reg;       // block word being assembled
    logic        lenblk_reg;

    // block buffer: 16 words, one port
    logic [31:0] mem [16];
    logic        mem_we;
    logic [3:0]  mem_addr;
    logic [31:0] mem_wdata, mem_rdata_reg;
    logic        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_addr];
    end

    sha256_pkg::core_ctl_t ctl;
    logic        restart, w_load;
    logic [31:0] h_word;

    sha256_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .restart (restart),
        .w_load  (w_load),
        .w_in    (mem_rdata_reg),
        .h_sel   (oidx_reg),
        .h_word  (h_word)
    );

    logic in_acc, out_acc;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_acc   = out_valid && !out_stall;
    assign out_data.digest_word = h_word;
    assign out_data.word_index  = oidx_reg;
    assign out_data.last_word   = (oidx_reg == 3'd7);

    // byte lane of the current partial word, big endian
    logic [31:0] word_ins, pad_word;
    logic [1:0]  lane;
    assign lane = pend_reg[1:0];
    always_comb
    begin
        word_ins = word_reg;
        case (lane)
            2'd0: word_ins = {in_data.data_byte, 24'h0};
            2'd1: word_ins[23:16] = in_data.data_byte;
            2'd2: word_ins[15:8]  = in_data.data_byte;
            default: word_ins[7:0] = in_data.data_byte;
        endcase
    end

    // padding word at widx_reg: partial word gets 0x80, later words zero, length last
    always_comb
    begin
        pad_word = 32'h0;
        if (!lenblk_reg && widx_reg == pend_reg[5:2])
        begin
            case (lane)
                2'd0: pad_word = {sha256_pkg::PAD_BYTE, 24'h0};
                2'd1: pad_word = {word_reg[31:24], sha256_pkg::PAD_BYTE, 16'h0};
                2'd2: pad_word = {word_reg[31:16], sha256_pkg::PAD_BYTE, 8'h0};
                default: pad_word = {word_reg[31:8], sha256_pkg::PAD_BYTE};
            endcase
        end
        if (!extra_reg && widx_reg == 4'd14)
            pad_word = bits_reg[63:32];
        if (!extra_reg && widx_reg == 4'd15)
            pad_word = bits_reg[31:0];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = widx_reg;
        mem_wdata = pad_word;
        if (state_reg == ST_IDLE)
        begin
            mem_addr  = pend_reg[5:2];
            mem_wdata = word_ins;
            mem_we    = in_acc && (in_data.action == sha256_pkg::ACT_ABSORB);
        end
        else if (state_reg == ST_PAD)
            mem_we = 1'b1;
    end

    assign w_load    = rd_valid_reg;
    assign ctl.init  = (state_reg == ST_LOAD) && (widx_reg == 4'd0) && !rd_valid_reg;
    assign ctl.step  = (state_reg == ST_ROUND) && !rd_valid_reg;
    assign ctl.round = round_reg;
    assign ctl.fold  = (state_reg == ST_FOLD);
    assign restart   = out_acc && (oidx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_reg     <= '0;
            bits_reg     <= '0;
            fin_reg      <= 1'b0;
            extra_reg    <= 1'b0;
            lenblk_reg   <= 1'b0;
            widx_reg     <= '0;
            round_reg    <= '0;
            oidx_reg     <= '0;
            word_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && in_data.action == sha256_pkg::ACT_ABSORB)
                    begin
                        word_reg <= word_ins;
                        pend_reg <= pend_reg + 6'd1;
                        bits_reg <= bits_reg + 64'd8;
                        if (pend_reg == 6'd63)
                        begin
                            state_reg <= ST_LOAD;
                            widx_reg  <= '0;
                        end
                    end
                    else if (in_acc)
                    begin
                        fin_reg    <= 1'b1;
                        extra_reg  <= (pend_reg >= 6'd56);
                        lenblk_reg <= 1'b0;
                        widx_reg   <= pend_reg[5:2];
                        state_reg  <= ST_PAD;
                    end
                end
                ST_PAD:
                begin
                    widx_reg <= widx_reg + 4'd1;
                    if (widx_reg == 4'd15)
                        state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    // read word widx; it is shifted into the window in the next cycle
                    rd_valid_reg <= 1'b1;
                    widx_reg     <= widx_reg + 4'd1;
                    if (widx_reg == 4'd15)
                    begin
                        state_reg <= ST_ROUND;
                        round_reg <= '0;
                    end
                end
                ST_ROUND:
                begin
                    // first cycle only lands word 15 in the window
                    if (!rd_valid_reg)
                    begin
                        round_reg <= round_reg + 6'd1;
                        if (round_reg == 6'd63)
                            state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    pend_reg <= '0;
                    widx_reg <= '0;
                    if (fin_reg && extra_reg)
                    begin
                        extra_reg  <= 1'b0;
                        lenblk_reg <= 1'b1;
                        state_reg  <= ST_PAD;
                    end
                    else if (fin_reg)
                    begin
                        oidx_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                        state_reg <= ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (out_acc)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            fin_reg   <= 1'b0;
                            bits_reg  <= '0;
                            pend_reg  <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // the last word of the window arrives in the first round cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 6'd0) |-> $past(rd_valid_reg) || rd_valid_reg)
        else $error("schedule load not aligned with rounds");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fin_reg && pend_reg == 6'd0)
        else $error("digest shown outside a finish");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_data.last_word) |=> state_reg == ST_IDLE && bits_reg == 64'd0)
        else $error("message state not restarted after digest");

endmodule
